[src/isat_pkg.sv]
// Shared types, widths and constant tables for the IMU scale and tilt core.
// Used by the square-root cells, the CORDIC cells, the rate scaler and the top level.
// No dependencies.
package isat_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    localparam int RAW_W     = 16;
    localparam int ACC_W     = 19;
    localparam int RATE_W    = 16;
    localparam int TILT_W    = 16;
    localparam int RANGE_W   = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 144;

    localparam int SUM_W      = 32;
    localparam int ROOT_W     = 28;
    localparam int REM_W      = 30;
    localparam int SQRT_STEPS = 28;

    localparam int CX_W          = 32;
    localparam int CZ_W          = 26;
    localparam int RND_W         = CZ_W - 8;
    localparam int TILT_PRESHIFT = 12;
    localparam int TILT_LIMIT    = 23040;

    localparam int GY_N_W   = 24;
    localparam int GY_R_W   = 24;
    localparam int GY_P_W   = GY_N_W + GY_R_W;
    localparam int GY_D_W   = 12;
    localparam int GY_REM_W = 14;
    localparam int GY_Q_W   = 16;

    localparam longint TWO32 = 64'h1_0000_0000;
    localparam logic [GY_R_W-1:0] GY_RECIP_0 = GY_R_W'(TWO32 / 64'd2620);
    localparam logic [GY_R_W-1:0] GY_RECIP_1 = GY_R_W'(TWO32 / 64'd1310);
    localparam logic [GY_R_W-1:0] GY_RECIP_2 = GY_R_W'(TWO32 / 64'd656);
    localparam logic [GY_R_W-1:0] GY_RECIP_3 = GY_R_W'(TWO32 / 64'd328);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_RANGE = 8'd0,
        REG_GYRO_RANGE  = 8'd1
    } t_reg_idx;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc_x;
        logic signed [ACC_W-1:0] acc_y;
        logic signed [ACC_W-1:0] acc_z;
        logic signed [RAW_W-1:0] a_x;
        logic signed [RAW_W-1:0] a_y;
        logic                    zero_x;
        logic                    zero_y;
    } t_side;

    typedef struct packed {
        logic signed [RATE_W-1:0] x;
        logic signed [RATE_W-1:0] y;
        logic signed [RATE_W-1:0] z;
    } t_rates;

    function automatic logic signed [CZ_W-1:0] atan_deg_q16(input int i);
        logic signed [CZ_W-1:0] v;
        case (i)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [GY_D_W-1:0] gyro_d2(input logic [RANGE_W-1:0] r);
        logic [GY_D_W-1:0] v;
        case (r)
            2'd0:    v = 12'd2620;
            2'd1:    v = 12'd1310;
            2'd2:    v = 12'd656;
            default: v = 12'd328;
        endcase
        return v;
    endfunction

    function automatic logic [GY_R_W-1:0] gyro_recip(input logic [RANGE_W-1:0] r);
        logic [GY_R_W-1:0] v;
        case (r)
            2'd0:    v = GY_RECIP_0;
            2'd1:    v = GY_RECIP_1;
            2'd2:    v = GY_RECIP_2;
            default: v = GY_RECIP_3;
        endcase
        return v;
    endfunction

endpackage

[src/isat_sqrt_cell.sv]
// One digit cell of the pipelined square root: two input bits in, one root bit out.
// Depends on isat_pkg.
module isat_sqrt_cell
    import isat_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_sqrt i_d,
    output t_sqrt o_q
);

    logic [1:0]        w_pair;
    logic [REM_W+1:0]  w_rem_sh;
    logic [REM_W+1:0]  w_trial;
    t_sqrt             n_q;
    t_sqrt             r_q;

    generate
        if (STEP <= 15) begin : g_bits
            assign w_pair = i_d.sum[31-2*STEP -: 2];
        end else begin : g_zero
            assign w_pair = 2'b00;
        end
    endgenerate

    always_comb begin
        w_rem_sh = {i_d.rem, w_pair};
        w_trial  = (REM_W+2)'({i_d.root, 2'b01});
        n_q.sum  = i_d.sum;
        if (w_rem_sh >= w_trial) begin
            n_q.rem  = REM_W'(w_rem_sh - w_trial);
            n_q.root = {i_d.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_q.rem  = REM_W'(w_rem_sh);
            n_q.root = {i_d.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

[src/isat_cordic_cell.sv]
// One vectoring CORDIC cell: a conditional shift-add rotation and an angle update.
// Depends on isat_pkg.
module isat_cordic_cell
    import isat_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_cordic i_d,
    output t_cordic o_q
);

    localparam logic signed [CZ_W-1:0] ANGLE = atan_deg_q16(STAGE);

    logic signed [CX_W-1:0] w_xs;
    logic signed [CX_W-1:0] w_ys;
    t_cordic                n_q;
    t_cordic                r_q;

    always_comb begin
        w_xs = i_d.x >>> STAGE;
        w_ys = i_d.y >>> STAGE;
        if (!i_d.y[CX_W-1]) begin
            n_q.x = i_d.x + w_ys;
            n_q.y = i_d.y - w_xs;
            n_q.z = i_d.z + ANGLE;
        end else begin
            n_q.x = i_d.x - w_ys;
            n_q.y = i_d.y + w_xs;
            n_q.z = i_d.z - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

[src/isat_gyro_unit.sv]
// Four-stage rate scaler: rounded division by the range divisor via a reciprocal product.
// Depends on isat_pkg.
module isat_gyro_unit
    import isat_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [RANGE_W-1:0] i_range,
    input  t_rates             i_raw,
    output t_rates             o_rate
);

    logic signed [RAW_W-1:0]  w_raw  [3];
    logic [GY_D_W-1:0]        w_d2;
    logic [GY_R_W-1:0]        w_recip;

    logic [GY_N_W-1:0]        r_n1   [3];
    logic                     r_neg1 [3];
    logic [GY_P_W-1:0]        r_p2   [3];
    logic [GY_N_W-1:0]        r_n2   [3];
    logic                     r_neg2 [3];
    logic [GY_Q_W-1:0]        r_qe3  [3];
    logic [GY_REM_W-1:0]      r_rem3 [3];
    logic                     r_neg3 [3];
    logic signed [RATE_W-1:0] r_out4 [3];

    assign w_raw[0] = i_raw.x;
    assign w_raw[1] = i_raw.y;
    assign w_raw[2] = i_raw.z;
    assign w_d2     = gyro_d2(i_range);
    assign w_recip  = gyro_recip(i_range);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                logic [RAW_W-1:0]    mag;
                logic [GY_N_W-1:0]   prod;
                logic [GY_Q_W-1:0]   q;
                mag = w_raw[k][RAW_W-1] ? RAW_W'(-w_raw[k]) : RAW_W'(w_raw[k]);
                r_n1[k]   <= (GY_N_W'(mag) << 8) + (GY_N_W'(mag) << 6)
                             + GY_N_W'(w_d2 >> 1);
                r_neg1[k] <= w_raw[k][RAW_W-1];

                r_p2[k]   <= GY_P_W'(r_n1[k]) * GY_P_W'(w_recip);
                r_n2[k]   <= r_n1[k];
                r_neg2[k] <= r_neg1[k];

                prod      = GY_N_W'(r_p2[k][GY_P_W-1:32]) * GY_N_W'(w_d2);
                r_qe3[k]  <= r_p2[k][GY_P_W-1:32];
                r_rem3[k] <= GY_REM_W'(r_n2[k] - prod);
                r_neg3[k] <= r_neg2[k];

                q = r_qe3[k] + ((r_rem3[k] >= GY_REM_W'(w_d2)) ? 16'd1 : 16'd0);
                r_out4[k] <= r_neg3[k] ? RATE_W'(-q) : RATE_W'(q);
            end
        end
    end

    assign o_rate.x = r_out4[0];
    assign o_rate.y = r_out4[1];
    assign o_rate.z = r_out4[2];

endmodule

[src/imu_scale_and_tilt_core.sv]
// Top level of the IMU scale and tilt core: stream ports, configuration, cell chains.
// Depends on isat_pkg, isat_sqrt_cell, isat_cordic_cell and isat_gyro_unit.
//
// Usage: one raw six-axis sample enters per request on the s_axis channel and one
// result leaves per request on the m_axis channel. Accelerometer values are scaled
// to g by the accel range, gyro values to deg/s by the gyro range, and two tilt
// angles are formed from the accelerometer by a 28-cell square-root chain followed
// by a chain of CORDIC_STAGES cells.
// The delay from input request to output valid is set by the length of the
// square-root and CORDIC cell chains.
// Throughput is one sample per cycle when not stalled; each cell hands its data on.
// When the receiver stalls with a result waiting, the whole chain holds and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and sets both range registers to zero.
// Range registers are written through the i_cfg channel, which is ready whenever
// reset is released; they must only change while no sample is in flight.
module imu_scale_and_tilt_core
    import isat_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // accel_x_g, accel_y_g, accel_z_g, rate_x_dps, rate_y_dps, rate_z_dps,
    // tilt_x_deg, tilt_y_deg, then zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int LAST   = SQRT_STEPS + 3 + CORDIC_STAGES;
    localparam int SIDE_N = LAST - 1;
    localparam int GY_N   = LAST - 5;

    logic               w_adv;
    logic               w_accept;
    logic [RANGE_W-1:0] r_accel_range;
    logic [RANGE_W-1:0] r_gyro_range;
    logic               r_vld [LAST+1];

    logic signed [RAW_W-1:0] r_ax, r_ay, r_az;
    t_rates                  r_graw;
    logic [SUM_W-1:0]        r_sq_x, r_sq_y, r_sq_z;
    t_sqrt                   r_s0x, r_s0y;
    t_side                   n_side;
    t_side                   r_side [SIDE_N];
    t_rates                  w_rate;
    t_rates                  r_gy [GY_N];

    t_sqrt   w_sx [SQRT_STEPS+1];
    t_sqrt   w_sy [SQRT_STEPS+1];
    t_cordic w_cx [CORDIC_STAGES+1];
    t_cordic w_cy [CORDIC_STAGES+1];

    logic signed [TILT_W-1:0] w_tilt_x, w_tilt_y;
    logic [M_TDATA_W-1:0]     r_out;

    function automatic logic signed [TILT_W-1:0] tilt_final(
        input logic signed [CZ_W-1:0]  z,
        input logic                    zero,
        input logic signed [RAW_W-1:0] a
    );
        logic signed [CZ_W-1:0]  zr;
        logic signed [RND_W-1:0] r;
        logic signed [TILT_W-1:0] v;
        zr = z + 26'sd128;
        r  = RND_W'(zr >>> 8);
        if (zero) begin
            if (a == 16'sd0) begin
                v = 16'sd0;
            end else if (a[RAW_W-1]) begin
                v = -16'sd23040;
            end else begin
                v = 16'sd23040;
            end
        end else if (r > RND_W'(TILT_LIMIT)) begin
            v = 16'sd23040;
        end else if (r < -RND_W'(TILT_LIMIT)) begin
            v = -16'sd23040;
        end else begin
            v = TILT_W'(r);
        end
        return v;
    endfunction

    assign w_adv         = !r_vld[LAST] || m_axis_tready;
    assign s_axis_tready = w_adv && i_rst_n;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_range <= '0;
            r_gyro_range  <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ACCEL_RANGE: r_accel_range <= i_cfg_data[RANGE_W-1:0];
                REG_GYRO_RANGE:  r_gyro_range  <= i_cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        n_side.acc_x  = ACC_W'(r_ax) <<< r_accel_range;
        n_side.acc_y  = ACC_W'(r_ay) <<< r_accel_range;
        n_side.acc_z  = ACC_W'(r_az) <<< r_accel_range;
        n_side.a_x    = r_ax;
        n_side.a_y    = r_ay;
        n_side.zero_x = (r_ay == 16'sd0) && (r_az == 16'sd0);
        n_side.zero_y = (r_ax == 16'sd0) && (r_az == 16'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ax     <= s_axis_tdata[15:0];
            r_ay     <= s_axis_tdata[31:16];
            r_az     <= s_axis_tdata[47:32];
            r_graw.x <= s_axis_tdata[63:48];
            r_graw.y <= s_axis_tdata[79:64];
            r_graw.z <= s_axis_tdata[95:80];

            r_sq_x <= SUM_W'(r_ax * r_ax);
            r_sq_y <= SUM_W'(r_ay * r_ay);
            r_sq_z <= SUM_W'(r_az * r_az);

            r_s0x.sum  <= r_sq_y + r_sq_z;
            r_s0x.rem  <= '0;
            r_s0x.root <= '0;
            r_s0y.sum  <= r_sq_x + r_sq_z;
            r_s0y.rem  <= '0;
            r_s0y.root <= '0;

            r_side[0] <= n_side;
            for (int k = 1; k < SIDE_N; k++) begin
                r_side[k] <= r_side[k-1];
            end

            r_gy[0] <= w_rate;
            for (int k = 1; k < GY_N; k++) begin
                r_gy[k] <= r_gy[k-1];
            end
        end
    end

    isat_gyro_unit u_gyro (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_range (r_gyro_range),
        .i_raw   (r_graw),
        .o_rate  (w_rate)
    );

    assign w_sx[0] = r_s0x;
    assign w_sy[0] = r_s0y;

    generate
        for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
            isat_sqrt_cell #(.STEP(j)) u_cell_x (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_d   (w_sx[j]),
                .o_q   (w_sx[j+1])
            );
            isat_sqrt_cell #(.STEP(j)) u_cell_y (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_d   (w_sy[j]),
                .o_q   (w_sy[j+1])
            );
        end
    endgenerate

    assign w_cx[0].x = CX_W'(w_sx[SQRT_STEPS].root);
    assign w_cx[0].y = CX_W'(r_side[SQRT_STEPS+1].a_x) <<< TILT_PRESHIFT;
    assign w_cx[0].z = '0;
    assign w_cy[0].x = CX_W'(w_sy[SQRT_STEPS].root);
    assign w_cy[0].y = CX_W'(r_side[SQRT_STEPS+1].a_y) <<< TILT_PRESHIFT;
    assign w_cy[0].z = '0;

    generate
        for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
            isat_cordic_cell #(.STAGE(i)) u_cell_x (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_d   (w_cx[i]),
                .o_q   (w_cx[i+1])
            );
            isat_cordic_cell #(.STAGE(i)) u_cell_y (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_d   (w_cy[i]),
                .o_q   (w_cy[i+1])
            );
        end
    endgenerate

    assign w_tilt_x = tilt_final(w_cx[CORDIC_STAGES].z, r_side[SIDE_N-1].zero_x,
                                 r_side[SIDE_N-1].a_x);
    assign w_tilt_y = tilt_final(w_cy[CORDIC_STAGES].z, r_side[SIDE_N-1].zero_y,
                                 r_side[SIDE_N-1].a_y);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= {7'd0, w_tilt_y, w_tilt_x,
                      r_gy[GY_N-1].z, r_gy[GY_N-1].y, r_gy[GY_N-1].x,
                      r_side[SIDE_N-1].acc_z, r_side[SIDE_N-1].acc_y,
                      r_side[SIDE_N-1].acc_x};
        end
    end

    assign m_axis_tvalid = r_vld[LAST];
    assign m_axis_tdata  = r_out;

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow the output stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_vld[0])
        else $error("accepted sample did not enter the chain");

    a_stall_holds_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld[0]) && $stable(r_out))
        else $error("chain moved during a stall");

    a_cfg_accel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && (i_cfg_index == REG_ACCEL_RANGE)
        |=> r_accel_range == $past(i_cfg_data[RANGE_W-1:0]))
        else $error("accel range write lost");

    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[120:105]) <= 16'sd23040)
                       && ($signed(m_axis_tdata[120:105]) >= -16'sd23040)
                       && ($signed(m_axis_tdata[136:121]) <= 16'sd23040)
                       && ($signed(m_axis_tdata[136:121]) >= -16'sd23040))
        else $error("tilt result out of range");

endmodule

[verif/imu_scale_and_tilt_core_test.sv]
// Testbench for imu_scale_and_tilt_core: random and directed six-axis samples,
// with the scaled values and CORDIC tilt angles predicted in the bench itself.
// Depends on isat_pkg and the core RTL.
module imu_scale_and_tilt_core_test;
    import isat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [RAW_W-1:0] gz, gy, gx, az, ay, ax;
    } t_sample;

    typedef struct {
        logic signed [ACC_W-1:0]  acc [3];
        logic signed [RATE_W-1:0] rate [3];
        logic signed [TILT_W-1:0] tilt [2];
    } t_scaled;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    imu_scale_and_tilt_core dut (.*);

    always #5 i_clk = ~i_clk;

    t_sample pending_samples[$];
    t_scaled expected_results[$];
    int      errors = 0;
    int      samples_sent = 0;
    int      results_seen = 0;
    int      hold_off = 0;
    bit      sender_paused = 0;
    logic [RANGE_W-1:0] accel_rng = '0, gyro_rng = '0;

    function automatic longint tilt_deg(longint a, longint b, longint c);
        longint unsigned s, v, rt, bit_v;
        longint x, y, z, xs, ys, r;
        s = b * b + c * c;
        if (s == 0) return (a == 0) ? 0 : (a > 0 ? TILT_LIMIT : -TILT_LIMIT);
        v = s << 24;
        rt = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= rt + bit_v) begin
                v -= rt + bit_v;
                rt = (rt >> 1) + bit_v;
            end else begin
                rt >>= 1;
            end
            bit_v >>= 2;
        end
        x = rt;
        y = a <<< 12;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF && i < ATAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_deg_q16(i);
            end else begin
                x -= ys; y += xs; z -= atan_deg_q16(i);
            end
        end
        r = (z + 128) >>> 8;
        if (r > TILT_LIMIT) r = TILT_LIMIT;
        if (r < -TILT_LIMIT) r = -TILT_LIMIT;
        return r;
    endfunction

    function automatic longint rate_dps(longint raw, logic [1:0] rng);
        longint unsigned d, m, q;
        case (rng)
            2'd0:    d = 1310;
            2'd1:    d = 655;
            2'd2:    d = 328;
            default: d = 164;
        endcase
        m = raw < 0 ? -raw : raw;
        q = (m * 320 + d) / (2 * d);
        return raw < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_scaled scale_sample(t_sample s);
        t_scaled e;
        longint a[3], g[3];
        a = '{s.ax, s.ay, s.az};
        g = '{s.gx, s.gy, s.gz};
        for (int i = 0; i < 3; i++) begin
            e.acc[i] = ACC_W'(a[i] <<< accel_rng);
            e.rate[i] = RATE_W'(rate_dps(g[i], gyro_rng));
        end
        e.tilt[0] = TILT_W'(tilt_deg(a[0], a[1], a[2]));
        e.tilt[1] = TILT_W'(tilt_deg(a[1], a[0], a[2]));
        return e;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sender: a request is predicted at the edge it is accepted.
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(scale_sample(t_sample'(s_axis_tdata)));
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0 && !sender_paused) begin
                    s_axis_tdata <= pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    tx_gap = gap_len();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver with random stalls and an occasional long hold-off.
    int rx_gap = 0;
    always @(posedge i_clk) begin
        t_scaled e, got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got.acc[0] = m_axis_tdata[0 +: ACC_W];
                got.acc[1] = m_axis_tdata[19 +: ACC_W];
                got.acc[2] = m_axis_tdata[38 +: ACC_W];
                got.rate[0] = m_axis_tdata[57 +: RATE_W];
                got.rate[1] = m_axis_tdata[73 +: RATE_W];
                got.rate[2] = m_axis_tdata[89 +: RATE_W];
                got.tilt[0] = m_axis_tdata[105 +: TILT_W];
                got.tilt[1] = m_axis_tdata[121 +: TILT_W];
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        if (got.acc[i] !== e.acc[i]) begin
                            $display("%0t: accel[%0d] expected %0d actual %0d",
                                     $time, i, e.acc[i], got.acc[i]);
                            errors++;
                        end
                        if (got.rate[i] !== e.rate[i]) begin
                            $display("%0t: rate[%0d] expected %0d actual %0d",
                                     $time, i, e.rate[i], got.rate[i]);
                            errors++;
                        end
                    end
                    for (int i = 0; i < 2; i++)
                        if (got.tilt[i] !== e.tilt[i]) begin
                            $display("%0t: tilt[%0d] expected %0d actual %0d",
                                     $time, i, e.tilt[i], got.tilt[i]);
                            errors++;
                        end
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                rx_gap = gap_len();
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_ACCEL_RANGE) accel_rng = val[1:0];
        else gyro_rng = val[1:0];
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (CORDIC_STAGES_DEF + 40) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        t_sample s;
        s = {$urandom, $urandom, $urandom};
        if ($urandom_range(0, 3) == 0) begin
            s.ax = $signed(16'($urandom_range(0, 64))) - 32;
            s.ay = $signed(16'($urandom_range(0, 64))) - 32;
            s.az = $signed(16'($urandom_range(0, 64))) - 32;
        end
        return s;
    endfunction

    localparam logic signed [15:0] MAXV = 16'sh7fff;
    localparam logic signed [15:0] MINV = -16'sh8000;

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(REG_ACCEL_RANGE, 8'd3);
        write_reg(REG_GYRO_RANGE, 8'd3);
        // Directed corners: zeros, b=c=0 both signs, extremes, equal axes.
        pending_samples.push_back('{0, 0, 0, 0, 0, 0});
        pending_samples.push_back('{MINV, MAXV, MINV, 0, 0, 100});
        pending_samples.push_back('{MAXV, MINV, MAXV, 0, 0, -100});
        pending_samples.push_back('{1, -1, 1, 0, 100, 0});
        pending_samples.push_back('{-1, 1, -1, 0, -100, 0});
        pending_samples.push_back('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
        pending_samples.push_back('{MINV, MINV, MINV, MINV, MINV, MINV});
        pending_samples.push_back('{-1, -1, -1, -1, -1, -1});
        pending_samples.push_back('{655, 1310, 164, 16384, 0, 0});
        pending_samples.push_back('{2, 3, 5, 1, 1, 0});
        pending_samples.push_back('{0, 0, 0, MINV, MAXV, MINV});
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_ACCEL_RANGE, 8'($urandom));
            write_reg(REG_GYRO_RANGE, 8'($urandom));
            if (ph == 1) begin
                write_reg(REG_ACCEL_RANGE, 8'd0);
                write_reg(REG_GYRO_RANGE, 8'd0);
            end
            for (int i = 0; i < 250; i++) pending_samples.push_back(rand_sample());
            if (ph == 2) begin
                while (pending_samples.size() > 200) @(posedge i_clk);
                hold_off = 300;
            end
            if (ph == 3) begin
                while (pending_samples.size() > 120) @(posedge i_clk);
                sender_paused = 1;
                while (expected_results.size() > 0 || s_axis_tvalid) @(posedge i_clk);
                sender_paused = 0;
            end
            drain();
        end
        $display("Sent %0d samples over several accel and gyro range settings,", samples_sent);
        $display("checked %0d results including zero-denominator tilt corners.", results_seen);
        if (errors == 0) $display("imu_scale_and_tilt_core_test OK");
        else $display("imu_scale_and_tilt_core_test NOT OK");
        $finish;
    end

    initial begin
        #3ms;
        $display("imu_scale_and_tilt_core_test NOT OK");
        $finish;
    end
endmodule
